[rtl/core/lodc_pkg.sv]
// ----------------------------------------------------------------------------
// lodc_pkg
// Types, codes and arithmetic helpers shared by the level-of-detail
// classifier modules.
// ----------------------------------------------------------------------------
package lodc_pkg;

  localparam int COORD_W   = 64;
  localparam int TIME_W    = 64;
  localparam int DIST_W    = 64;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SIGN_BIT  = 63;

  localparam logic ACTION_SUBJECT = 1'b0;
  localparam logic ACTION_VIEWER  = 1'b1;

  localparam logic [1:0] LEVEL_FULL       = 2'd0;
  localparam logic [1:0] LEVEL_SIMPLIFIED = 2'd1;
  localparam logic [1:0] LEVEL_SLEEPING   = 2'd2;
  localparam logic [1:0] LEVEL_UNLOADED   = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_POLICY   = 2'd1;
  localparam logic [1:0] ERR_BACKWARD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_RADIUS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIMPLIFIED_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_INTERVAL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIMPLIFIED_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEPING_INTERVAL = 3'd4;

  localparam logic [CFG_W-1:0] RST_FULL_RADIUS         = 32'd64;
  localparam logic [CFG_W-1:0] RST_SIMPLIFIED_RADIUS   = 32'd256;
  localparam logic [CFG_W-1:0] RST_FULL_INTERVAL       = 32'd50;
  localparam logic [CFG_W-1:0] RST_SIMPLIFIED_INTERVAL = 32'd200;
  localparam logic [CFG_W-1:0] RST_SLEEPING_INTERVAL   = 32'd1000;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      asleep;
    logic                      forced_valid;
    logic [1:0]                forced_level;
    logic [TIME_W-1:0]         now_ms;
    logic [TIME_W-1:0]         last_update_ms;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic [1:0]        level;
    logic [DIST_W-1:0] nearest_dist_sq;
    logic [TIME_W-1:0] elapsed_ms;
    logic [CFG_W-1:0]  interval_ms;
    logic              due;
    logic [TIME_W-1:0] offline_ms;
    logic [1:0]        error;
  } result_t;

  typedef struct packed {
    logic        asleep;
    logic        forced_valid;
    logic [1:0]  forced_level;
  } subj_flags_t;

  // One entry of the queue between front and back. The value is the elapsed
  // time for a subject and the squared distance for a viewer.
  typedef struct packed {
    logic              kind;
    logic              last;
    subj_flags_t       flags;
    logic              backward;
    logic [DIST_W-1:0] value;
  } mid_entry_t;

  // Absolute difference of two signed coordinates, exact over the full range.
  function automatic logic [DIST_W-1:0] axis_gap(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] l;
    logic [COORD_W-1:0] r;
    logic [COORD_W:0]   d;
    l = a ^ (COORD_W'(1) << SIGN_BIT);
    r = b ^ (COORD_W'(1) << SIGN_BIT);
    d = {1'b0, l} - {1'b0, r};
    return d[COORD_W] ? (r - l) : d[COORD_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] sat_sq(input logic [DIST_W-1:0] v);
    logic [DIST_W-1:0] p;
    p = DIST_W'(v[31:0]) * DIST_W'(v[31:0]);
    return (|v[DIST_W-1:32]) ? DIST_MAX : p;
  endfunction

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

endpackage

[rtl/core/lodc_fifo.sv]
// ----------------------------------------------------------------------------
// lodc_fifo
// Small register queue with an occupancy count; depth is a power of two.
// ----------------------------------------------------------------------------
module lodc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW    = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);

endmodule

[rtl/core/lodc_front.sv]
// ----------------------------------------------------------------------------
// lodc_front
// Accepts items, holds the subject position and computes the saturated
// squared viewer distance in three stages before writing the mid queue.
// ----------------------------------------------------------------------------
module lodc_front #(
  parameter int MID_DEPTH = 8,
  localparam int CNT_W = $clog2(MID_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lodc_pkg::item_t      item,
  output logic                 full,
  input  logic [CNT_W-1:0]     mid_count,
  output logic                 mid_push,
  output lodc_pkg::mid_entry_t mid_entry
);

  logic accept;

  logic [lodc_pkg::COORD_W-1:0] subject_x;
  logic [lodc_pkg::COORD_W-1:0] subject_y;
  logic [lodc_pkg::COORD_W-1:0] subject_z;

  logic s1_v, s2_v, s3_v;

  logic                       s1_kind, s1_last, s1_backward;
  lodc_pkg::subj_flags_t      s1_flags;
  logic [lodc_pkg::DIST_W-1:0] s1_gx, s1_gy, s1_gz;
  logic [lodc_pkg::TIME_W-1:0] s1_elapsed;

  logic                       s2_kind, s2_last, s2_backward;
  lodc_pkg::subj_flags_t      s2_flags;
  logic [lodc_pkg::DIST_W-1:0] s2_qx, s2_qy, s2_qz;
  logic [lodc_pkg::TIME_W-1:0] s2_elapsed;

  logic                       s3_kind, s3_last, s3_backward;
  lodc_pkg::subj_flags_t      s3_flags;
  logic [lodc_pkg::DIST_W-1:0] s3_sum_xy, s3_qz;
  logic [lodc_pkg::TIME_W-1:0] s3_elapsed;

  logic [CNT_W:0] credits_used;

  // Every transaction in the stages already owns a place in the mid queue.
  assign credits_used = {1'b0, mid_count} + (CNT_W + 1)'(s1_v) + (CNT_W + 1)'(s2_v)
                      + (CNT_W + 1)'(s3_v);
  assign full   = (credits_used >= (CNT_W + 1)'(MID_DEPTH));
  assign accept = push & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      subject_x <= '0;
      subject_y <= '0;
      subject_z <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
    end else begin
      if (accept && item.action == lodc_pkg::ACTION_SUBJECT) begin
        subject_x <= item.pos_x;
        subject_y <= item.pos_y;
        subject_z <= item.pos_z;
      end
      s1_v <= accept;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind               <= item.action;
    s1_last               <= item.last;
    s1_flags.asleep       <= item.asleep;
    s1_flags.forced_valid <= item.forced_valid;
    s1_flags.forced_level <= item.forced_level;
    s1_backward           <= (item.now_ms < item.last_update_ms);
    s1_elapsed            <= item.now_ms - item.last_update_ms;
    s1_gx                 <= lodc_pkg::axis_gap(subject_x, item.pos_x);
    s1_gy                 <= lodc_pkg::axis_gap(subject_y, item.pos_y);
    s1_gz                 <= lodc_pkg::axis_gap(subject_z, item.pos_z);

    s2_kind     <= s1_kind;
    s2_last     <= s1_last;
    s2_flags    <= s1_flags;
    s2_backward <= s1_backward;
    s2_elapsed  <= s1_elapsed;
    s2_qx       <= lodc_pkg::sat_sq(s1_gx);
    s2_qy       <= lodc_pkg::sat_sq(s1_gy);
    s2_qz       <= lodc_pkg::sat_sq(s1_gz);

    s3_kind     <= s2_kind;
    s3_last     <= s2_last;
    s3_flags    <= s2_flags;
    s3_backward <= s2_backward;
    s3_elapsed  <= s2_elapsed;
    s3_sum_xy   <= lodc_pkg::sat_add(s2_qx, s2_qy);
    s3_qz       <= s2_qz;
  end

  always_comb begin
    mid_entry.kind     = s3_kind;
    mid_entry.last     = s3_last;
    mid_entry.flags    = s3_flags;
    mid_entry.backward = s3_backward;
    mid_entry.value    = (s3_kind == lodc_pkg::ACTION_SUBJECT) ? s3_elapsed
                       : lodc_pkg::sat_add(s3_sum_xy, s3_qz);
  end

  assign mid_push = s3_v;

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> (mid_count < CNT_W'(MID_DEPTH)))
    else $error("mid queue written while full");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits_used <= (CNT_W + 1)'(MID_DEPTH))
    else $error("more transactions in flight than mid queue places");

endmodule

[rtl/core/lodc_back.sv]
// ----------------------------------------------------------------------------
// lodc_back
// Holds the policy registers and the subject timing, keeps the running
// minimum distance and forms one decision for each closing transaction.
// ----------------------------------------------------------------------------
module lodc_back #(
  parameter int OUT_DEPTH = 4,
  localparam int CNT_W = $clog2(OUT_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [lodc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lodc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              mid_empty,
  input  lodc_pkg::mid_entry_t              mid_entry,
  output logic                              mid_pop,
  input  logic [CNT_W-1:0]                  out_count,
  output logic                              out_push,
  output lodc_pkg::result_t                 out_data
);

  localparam logic [lodc_pkg::DIST_W-1:0] RST_FULL_SQ =
    lodc_pkg::DIST_W'(lodc_pkg::RST_FULL_RADIUS) * lodc_pkg::DIST_W'(lodc_pkg::RST_FULL_RADIUS);
  localparam logic [lodc_pkg::DIST_W-1:0] RST_SIMP_SQ =
    lodc_pkg::DIST_W'(lodc_pkg::RST_SIMPLIFIED_RADIUS)
    * lodc_pkg::DIST_W'(lodc_pkg::RST_SIMPLIFIED_RADIUS);

  logic [lodc_pkg::CFG_W-1:0] full_reach, simp_reach;
  logic [lodc_pkg::CFG_W-1:0] full_interval_ms, simplified_interval_ms, sleeping_interval_ms;
  logic [lodc_pkg::DIST_W-1:0] full_sq, simp_sq;
  logic                        policy_ok;

  lodc_pkg::subj_flags_t        held_flags, held_flags_next;
  logic [lodc_pkg::TIME_W-1:0]  held_elapsed, held_elapsed_next;
  logic                         held_backward, held_backward_next;
  logic [lodc_pkg::DIST_W-1:0]  best_dist_sq, best_dist_sq_next;

  logic                         b1_v;
  lodc_pkg::subj_flags_t        b1_flags;
  logic [lodc_pkg::TIME_W-1:0]  b1_elapsed;
  logic                         b1_backward;
  logic [lodc_pkg::DIST_W-1:0]  b1_best;

  logic       near_full, near_simp;
  logic       due_full, due_simp, due_sleep;
  logic [1:0] level;

  // Room in the result queue is reserved for a decision still in the stage.
  assign mid_pop = ~mid_empty
                 & (({1'b0, out_count} + (CNT_W + 1)'(b1_v)) < (CNT_W + 1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      full_reach             <= lodc_pkg::RST_FULL_RADIUS;
      simp_reach             <= lodc_pkg::RST_SIMPLIFIED_RADIUS;
      full_interval_ms       <= lodc_pkg::RST_FULL_INTERVAL;
      simplified_interval_ms <= lodc_pkg::RST_SIMPLIFIED_INTERVAL;
      sleeping_interval_ms   <= lodc_pkg::RST_SLEEPING_INTERVAL;
      full_sq                <= RST_FULL_SQ;
      simp_sq                <= RST_SIMP_SQ;
      policy_ok              <= 1'b1;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          lodc_pkg::REG_FULL_RADIUS:         full_reach             <= cfg_data;
          lodc_pkg::REG_SIMPLIFIED_RADIUS:   simp_reach             <= cfg_data;
          lodc_pkg::REG_FULL_INTERVAL:       full_interval_ms       <= cfg_data;
          lodc_pkg::REG_SIMPLIFIED_INTERVAL: simplified_interval_ms <= cfg_data;
          lodc_pkg::REG_SLEEPING_INTERVAL:   sleeping_interval_ms   <= cfg_data;
          default: begin
          end
        endcase
      end
      // Derived policy values settle in the cycle after a write; the user must keep
      // the block idle while it is configured, which the block does not enforce.
      full_sq   <= lodc_pkg::DIST_W'(full_reach) * lodc_pkg::DIST_W'(full_reach);
      simp_sq   <= lodc_pkg::DIST_W'(simp_reach)
                 * lodc_pkg::DIST_W'(simp_reach);
      policy_ok <= (full_reach <= simp_reach)
                 && (full_interval_ms != '0) && (simplified_interval_ms != '0)
                 && (sleeping_interval_ms != '0)
                 && (full_interval_ms <= simplified_interval_ms)
                 && (simplified_interval_ms <= sleeping_interval_ms);
    end
  end

  always_comb begin
    held_flags_next    = held_flags;
    held_elapsed_next  = held_elapsed;
    held_backward_next = held_backward;
    best_dist_sq_next  = best_dist_sq;
    if (mid_entry.kind == lodc_pkg::ACTION_SUBJECT) begin
      held_flags_next    = mid_entry.flags;
      held_elapsed_next  = mid_entry.value;
      held_backward_next = mid_entry.backward;
      best_dist_sq_next  = lodc_pkg::DIST_MAX;
    end else if (mid_entry.value < best_dist_sq) begin
      best_dist_sq_next = mid_entry.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flags    <= '0;
      held_elapsed  <= '0;
      held_backward <= 1'b0;
      best_dist_sq  <= lodc_pkg::DIST_MAX;
      b1_v          <= 1'b0;
    end else begin
      if (mid_pop) begin
        held_flags    <= held_flags_next;
        held_elapsed  <= held_elapsed_next;
        held_backward <= held_backward_next;
        best_dist_sq  <= best_dist_sq_next;
      end
      b1_v <= mid_pop & mid_entry.last;
    end
  end

  always_ff @(posedge clk) begin
    b1_flags    <= held_flags_next;
    b1_elapsed  <= held_elapsed_next;
    b1_backward <= held_backward_next;
    b1_best     <= best_dist_sq_next;
  end

  assign near_full = (b1_best <= full_sq);
  assign near_simp = (b1_best <= simp_sq);
  assign due_full  = (b1_elapsed >= lodc_pkg::TIME_W'(full_interval_ms));
  assign due_simp  = (b1_elapsed >= lodc_pkg::TIME_W'(simplified_interval_ms));
  assign due_sleep = (b1_elapsed >= lodc_pkg::TIME_W'(sleeping_interval_ms));

  always_comb begin
    if (b1_flags.forced_valid) begin
      level = b1_flags.forced_level;
    end else if (near_full) begin
      level = b1_flags.asleep ? lodc_pkg::LEVEL_SLEEPING : lodc_pkg::LEVEL_FULL;
    end else if (near_simp) begin
      level = b1_flags.asleep ? lodc_pkg::LEVEL_SLEEPING : lodc_pkg::LEVEL_SIMPLIFIED;
    end else begin
      level = lodc_pkg::LEVEL_UNLOADED;
    end
  end

  always_comb begin
    out_data = '0;
    if (!policy_ok) begin
      out_data.error = lodc_pkg::ERR_POLICY;
    end else if (b1_backward) begin
      out_data.error = lodc_pkg::ERR_BACKWARD;
    end else begin
      out_data.level           = level;
      out_data.nearest_dist_sq = b1_best;
      out_data.elapsed_ms      = b1_elapsed;
      out_data.error           = lodc_pkg::ERR_NONE;
      unique case (level)
        lodc_pkg::LEVEL_FULL: begin
          out_data.interval_ms = full_interval_ms;
          out_data.due         = due_full;
        end
        lodc_pkg::LEVEL_SIMPLIFIED: begin
          out_data.interval_ms = simplified_interval_ms;
          out_data.due         = due_simp;
        end
        lodc_pkg::LEVEL_SLEEPING: begin
          out_data.interval_ms = sleeping_interval_ms;
          out_data.due         = due_sleep;
        end
        default: begin
          out_data.offline_ms = b1_elapsed;
        end
      endcase
    end
  end

  assign out_push = b1_v;

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    b1_v |-> (out_count < CNT_W'(OUT_DEPTH)))
    else $error("result queue written while full");

  a_interval_matches_level: assert property (@(posedge clk) disable iff (rst)
    (b1_v && out_data.error == lodc_pkg::ERR_NONE)
      |-> ((out_data.level == lodc_pkg::LEVEL_UNLOADED) == (out_data.interval_ms == '0)))
    else $error("interval does not agree with the level");

  a_error_clears_fields: assert property (@(posedge clk) disable iff (rst)
    (b1_v && out_data.error != lodc_pkg::ERR_NONE)
      |-> (out_data.nearest_dist_sq == '0 && out_data.due == 1'b0))
    else $error("decision with an error carries data");

endmodule

[rtl/core/nearest_viewer_lod_classifier.sv]
// ----------------------------------------------------------------------------
// nearest_viewer_lod_classifier
// Picks a subject's level of detail from its nearest viewer and its timing.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port: an item is taken on a clock edge
// with push high and full low. A subject item starts a group, viewer items
// follow, and the item with last set closes it with one decision. Results
// leave through a second queue-style port: while empty is low the oldest
// decision is on result, and it is taken on an edge with pop high.
// The user must write the policy registers through cfg_wen, cfg_index
// and cfg_data only while no transaction is in flight; the block does
// not enforce this. An item can be taken every cycle while full is low.
// After its closing item is taken, the axis gaps are registered, then the
// squares, the sum, the mid queue write, the minimum update and the result
// queue write follow in order; a full result queue can stall the back end.
// If the receiver stalls, the four-entry result queue fills, the back end
// stops, the eight-entry mid queue fills behind it and full rises.
// Reset restores the policy registers to their defaults, clears both
// queues and the subject state, and sets the running minimum to its maximum.
// ----------------------------------------------------------------------------
module nearest_viewer_lod_classifier #(
  parameter int MID_DEPTH = 8,
  parameter int OUT_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  lodc_pkg::item_t                item,
  output logic                           empty,
  input  logic                           pop,
  output lodc_pkg::result_t              result,
  input  logic                           cfg_wen,
  input  logic [lodc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lodc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int MID_W     = $bits(lodc_pkg::mid_entry_t);
  localparam int OUT_W     = $bits(lodc_pkg::result_t);

  logic                  mid_push, mid_pop, mid_empty;
  logic [MID_CNT_W-1:0]  mid_count;
  lodc_pkg::mid_entry_t  mid_wr_entry;
  logic [MID_W-1:0]      mid_rd_bits;
  lodc_pkg::mid_entry_t  mid_rd_entry;

  logic                  out_push, out_pop;
  logic [OUT_CNT_W-1:0]  out_count;
  lodc_pkg::result_t     out_wr_data;
  logic [OUT_W-1:0]      out_rd_bits;

  lodc_front #(.MID_DEPTH(MID_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .mid_count (mid_count),
    .mid_push  (mid_push),
    .mid_entry (mid_wr_entry)
  );

  lodc_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (mid_wr_entry),
    .rd_en   (mid_pop),
    .rd_data (mid_rd_bits),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  assign mid_rd_entry = lodc_pkg::mid_entry_t'(mid_rd_bits);

  lodc_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mid_empty (mid_empty),
    .mid_entry (mid_rd_entry),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_wr_data)
  );

  assign out_pop = pop & ~empty;

  lodc_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_wr_data),
    .rd_en   (out_pop),
    .rd_data (out_rd_bits),
    .empty   (empty),
    .count   (out_count)
  );

  assign result = lodc_pkg::result_t'(out_rd_bits);

endmodule
